// File: rtl/rau_pkg.sv
// Package for the rational arithmetic unit: widths, operation and order codes,
// and the command/status structs shared by the controller and the datapath.
// No dependencies.
package rau_pkg;

	localparam int NUM_WIDTH = 32;
	localparam int DEN_WIDTH = NUM_WIDTH - 1;
	localparam int MAG_WIDTH = 64;
	localparam int RES_DEN_WIDTH = 62;
	localparam int CNT_WIDTH = 7;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_MUL = 2'd1;
	localparam logic [1:0] OP_CMP = 2'd2;

	localparam logic [1:0] ORD_LESS = 2'd0;
	localparam logic [1:0] ORD_EQUAL = 2'd1;
	localparam logic [1:0] ORD_GREATER = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture input word
		logic mul;        // form cross products
		logic combine;    // form numerator/denominator, or compare
		logic gcd_step;   // one bit of x mod y, or rotate x, y <= y, x mod y
		logic div_init;   // start dividing num and den by gcd
		logic div_step;   // one restoring division bit
		logic finish;     // write result registers
	} rau_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_cmp;     // operation is compare or unused
		logic trivial;    // zero numerator or denominator
		logic y_zero;     // gcd remainder operand is zero
		logic mod_done;   // current mod finished
		logic div_done;   // quotient bits all formed
	} rau_sts_t;

endpackage

// File: rtl/rau_datapath.sv
// Datapath of the rational arithmetic unit: input capture, four 32x32
// multipliers, a bit-serial remainder/divide unit for gcd and reduction.
// Depends on rau_pkg.
module rau_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rau_pkg::rau_cmd_t                 cmd,
	output rau_pkg::rau_sts_t                 sts,
	input  logic [1:0]                        operation,
	input  logic signed [rau_pkg::NUM_WIDTH-1:0] a_num,
	input  logic [rau_pkg::DEN_WIDTH-1:0]     a_den,
	input  logic signed [rau_pkg::NUM_WIDTH-1:0] b_num,
	input  logic [rau_pkg::DEN_WIDTH-1:0]     b_den,
	output logic signed [rau_pkg::MAG_WIDTH-1:0] res_num,
	output logic [rau_pkg::RES_DEN_WIDTH-1:0] res_den,
	output logic [1:0]                        order
);
	import rau_pkg::*;

	logic [1:0] op_q;
	logic signed [NUM_WIDTH-1:0] an_q, bn_q;
	logic [DEN_WIDTH-1:0] ad_q, bd_q;
	logic signed [MAG_WIDTH-1:0] p_ad_q, p_bc_q, p_nn_q;
	logic [MAG_WIDTH-1:0] p_dd_q;
	logic neg_q;
	logic [MAG_WIDTH-1:0] mag_q, den_q;
	logic [MAG_WIDTH-1:0] x_q, y_q;
	logic [MAG_WIDTH-1:0] rem_q, dvd_q, quo2_q, rem2_q;
	logic [CNT_WIDTH-1:0] bit_q;
	logic [1:0] ord_q;
	logic signed [MAG_WIDTH-1:0] n_sum;
	logic [MAG_WIDTH:0] trial, trial2;
	logic [MAG_WIDTH-1:0] rem_sh, rem2_sh;

	assign n_sum = (op_q == OP_ADD) ? (p_ad_q + p_bc_q) : p_nn_q;

	// Restoring step shared by mod (on rem_q/dvd_q) and division of num.
	assign rem_sh = {rem_q[MAG_WIDTH-2:0], dvd_q[MAG_WIDTH-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, y_q};
	assign rem2_sh = {rem2_q[MAG_WIDTH-2:0], quo2_q[MAG_WIDTH-1]};
	assign trial2 = {1'b0, rem2_sh} - {1'b0, x_q};

	assign sts.is_cmp = (op_q != OP_ADD) && (op_q != OP_MUL);
	assign sts.trivial = (mag_q == '0) || (den_q == '0);
	assign sts.y_zero = (y_q == '0);
	assign sts.mod_done = (bit_q == '0);
	assign sts.div_done = (bit_q == '0);

	always_ff @(posedge clk) begin
		// input capture
		if (cmd.load) begin
			op_q <= operation;
			an_q <= a_num;
			bn_q <= b_num;
			ad_q <= a_den;
			bd_q <= b_den;
		end
		// products; one per multiplier lane, registered
		if (cmd.mul) begin
			p_ad_q <= MAG_WIDTH'(an_q) * MAG_WIDTH'($signed({1'b0, bd_q}));
			p_bc_q <= MAG_WIDTH'(bn_q) * MAG_WIDTH'($signed({1'b0, ad_q}));
			p_nn_q <= MAG_WIDTH'(an_q) * MAG_WIDTH'(bn_q);
			p_dd_q <= MAG_WIDTH'(ad_q) * MAG_WIDTH'(bd_q);
		end
		if (cmd.combine) begin
			neg_q <= n_sum[MAG_WIDTH-1];
			mag_q <= n_sum[MAG_WIDTH-1] ? MAG_WIDTH'(-n_sum) : n_sum;
			den_q <= p_dd_q;
			x_q <= n_sum[MAG_WIDTH-1] ? MAG_WIDTH'(-n_sum) : n_sum;
			y_q <= p_dd_q;
			rem_q <= '0;
			dvd_q <= n_sum[MAG_WIDTH-1] ? MAG_WIDTH'(-n_sum) : n_sum;
			bit_q <= CNT_WIDTH'(MAG_WIDTH);
			if (p_ad_q < p_bc_q)
				ord_q <= ORD_LESS;
			else if (p_ad_q > p_bc_q)
				ord_q <= ORD_GREATER;
			else
				ord_q <= ORD_EQUAL;
		end
		// x mod y, one bit per cycle; on completion rotate x, y <= y, rem
		if (cmd.gcd_step) begin
			if (bit_q != '0) begin
				rem_q <= trial[MAG_WIDTH] ? rem_sh : trial[MAG_WIDTH-1:0];
				dvd_q <= {dvd_q[MAG_WIDTH-2:0], 1'b0};
				bit_q <= bit_q - CNT_WIDTH'(1);
			end else begin
				x_q <= y_q;
				y_q <= rem_q;
				dvd_q <= y_q;
				rem_q <= '0;
				bit_q <= CNT_WIDTH'(MAG_WIDTH);
			end
		end
		// x_q holds gcd: divide mag (dvd/rem) and den (quo2/rem2) in parallel
		if (cmd.div_init) begin
			y_q <= x_q;
			dvd_q <= mag_q;
			rem_q <= '0;
			quo2_q <= den_q;
			rem2_q <= '0;
			bit_q <= CNT_WIDTH'(MAG_WIDTH);
		end
		if (cmd.div_step) begin
			rem_q <= trial[MAG_WIDTH] ? rem_sh : trial[MAG_WIDTH-1:0];
			dvd_q <= {dvd_q[MAG_WIDTH-2:0], ~trial[MAG_WIDTH]};
			rem2_q <= trial2[MAG_WIDTH] ? rem2_sh : trial2[MAG_WIDTH-1:0];
			quo2_q <= {quo2_q[MAG_WIDTH-2:0], ~trial2[MAG_WIDTH]};
			bit_q <= bit_q - CNT_WIDTH'(1);
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_num <= '0;
			res_den <= RES_DEN_WIDTH'(1);
			order <= ORD_EQUAL;
		end else if (cmd.finish) begin
			if (sts.is_cmp || sts.trivial) begin
				res_num <= '0;
				res_den <= RES_DEN_WIDTH'(1);
				order <= (op_q == OP_CMP) ? ord_q : ORD_EQUAL;
			end else begin
				res_num <= neg_q ? MAG_WIDTH'(-dvd_q) : dvd_q;
				res_den <= quo2_q[RES_DEN_WIDTH-1:0];
				order <= ORD_EQUAL;
			end
		end
	end

endmodule

// File: rtl/rau_ctrl.sv
// Controller of the rational arithmetic unit: sequences load, multiply,
// gcd iterations, division and output handshake. Depends on rau_pkg.
module rau_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output rau_pkg::rau_cmd_t cmd,
	input  rau_pkg::rau_sts_t sts
);
	import rau_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL = 3'd1;
	localparam logic [2:0] S_COMB = 3'd2;
	localparam logic [2:0] S_GCD = 3'd3;
	localparam logic [2:0] S_DIV = 3'd4;
	localparam logic [2:0] S_FIN = 3'd5;

	logic [2:0] state_q;
	logic out_valid_q;
	logic out_free;
	logic take;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign take = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd = '0;
		cmd.load = take;
		cmd.mul = (state_q == S_MUL);
		cmd.combine = (state_q == S_COMB);
		cmd.gcd_step = (state_q == S_GCD) && !(sts.mod_done && sts.y_zero);
		cmd.div_init = (state_q == S_GCD) && sts.mod_done && sts.y_zero;
		cmd.div_step = (state_q == S_DIV) && !sts.div_done;
		cmd.finish = (state_q == S_FIN) && out_free;
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (take) state_q <= S_MUL;
				S_MUL: state_q <= S_COMB;
				S_COMB: state_q <= S_GCD;
				S_GCD: begin
					if (sts.is_cmp || sts.trivial)
						state_q <= S_FIN;
					else if (sts.mod_done && sts.y_zero)
						state_q <= S_DIV;
				end
				S_DIV: if (sts.div_done) state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !take) else $error("item taken while busy");
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> out_valid_q) else $error("result lost");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q) else $error("result dropped");

endmodule

// File: rtl/rational_arith_unit.sv
// Rational arithmetic unit: adds, multiplies (reduced by gcd) or compares two
// fractions. One word at a time: add or multiply runs the Euclid steps, each a
// bit-serial remainder followed by a rotation; once the divisor is zero a further
// remainder runs out, and then numerator and denominator are divided by the gcd.
// Compare, the unused selector and a zero numerator or denominator skip the gcd
// and the division. The next word is taken in the cycle after the result is
// registered; a stalled result holds the next result, and the unit with it,
// until it is taken.
// Depends on rau_pkg, rau_ctrl, rau_datapath.
module rational_arith_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           operation,
	input  logic signed [rau_pkg::NUM_WIDTH-1:0] a_num,
	input  logic [rau_pkg::DEN_WIDTH-1:0]        a_den,
	input  logic signed [rau_pkg::NUM_WIDTH-1:0] b_num,
	input  logic [rau_pkg::DEN_WIDTH-1:0]        b_den,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [rau_pkg::MAG_WIDTH-1:0] res_num,
	output logic [rau_pkg::RES_DEN_WIDTH-1:0]    res_den,
	output logic [1:0]                           order
);
	import rau_pkg::*;

	rau_cmd_t cmd;
	rau_sts_t sts;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
	);

	rau_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .operation(operation),
		.a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.res_num(res_num), .res_den(res_den), .order(order)
	);

endmodule

// File: verif/rational_arith_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for rational_arith_unit: random and directed fraction words,
// predicted results checked against the block's output in order.
// Depends on rau_pkg and the RTL of rational_arith_unit.
module rational_arith_unit_tb;
	import rau_pkg::*;

	typedef struct {
		logic signed [MAG_WIDTH-1:0] num;
		logic [RES_DEN_WIDTH-1:0]    den;
		logic [1:0]                  ord;
	} fraction_res_t;

	// Predicts each result from an accepted word and checks results in order.
	class fraction_board;
		fraction_res_t pending[$];
		int errors = 0;
		int words_in = 0;
		int words_out = 0;

		function automatic longint unsigned euclid(longint unsigned x,
				longint unsigned y);
			longint unsigned t;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			return x;
		endfunction

		function automatic fraction_res_t reduce(longint n, longint d);
			fraction_res_t r;
			logic neg;
			longint unsigned mag, dn, g;
			neg = n < 0;
			mag = neg ? -n : n;
			dn = d;
			r.num = 0;
			r.den = 1;
			r.ord = ORD_EQUAL;
			if (mag != 0 && dn != 0) begin
				g = euclid(mag, dn);
				mag = mag / g;
				dn = dn / g;
				r.num = neg ? -mag : mag;
				r.den = dn[RES_DEN_WIDTH-1:0];
			end
			return r;
		endfunction

		function void note(logic [1:0] op, logic signed [NUM_WIDTH-1:0] an,
				logic [DEN_WIDTH-1:0] ad, logic signed [NUM_WIDTH-1:0] bn,
				logic [DEN_WIDTH-1:0] bd);
			fraction_res_t r;
			longint lan, lad, lbn, lbd, lhs, rhs;
			lan = an;
			lbn = bn;
			lad = {33'd0, ad};
			lbd = {33'd0, bd};
			r.num = 0;
			r.den = 1;
			r.ord = ORD_EQUAL;
			case (op)
				OP_ADD: r = reduce(lan * lbd + lbn * lad, lad * lbd);
				OP_MUL: r = reduce(lan * lbn, lad * lbd);
				OP_CMP: begin
					lhs = lan * lbd;
					rhs = lbn * lad;
					r.ord = (lhs < rhs) ? ORD_LESS
						: ((lhs > rhs) ? ORD_GREATER : ORD_EQUAL);
				end
				default: ;
			endcase
			pending = {pending, r};
			words_in++;
		endfunction

		function void check(logic signed [MAG_WIDTH-1:0] num,
				logic [RES_DEN_WIDTH-1:0] den, logic [1:0] ord);
			fraction_res_t e;
			words_out++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %0d/%0d order %0d", $time, num, den, ord);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (num !== e.num) begin
				$display("%0t: res_num expected %0d actual %0d", $time, e.num, num);
				errors++;
			end
			if (den !== e.den) begin
				$display("%0t: res_den expected %0d actual %0d", $time, e.den, den);
				errors++;
			end
			if (ord !== e.ord) begin
				$display("%0t: order expected %0d actual %0d", $time, e.ord, ord);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] operation = OP_ADD;
	logic signed [NUM_WIDTH-1:0] a_num = 0;
	logic [DEN_WIDTH-1:0] a_den = 1;
	logic signed [NUM_WIDTH-1:0] b_num = 0;
	logic [DEN_WIDTH-1:0] b_den = 1;
	logic out_valid;
	logic out_stall = 0;
	logic signed [MAG_WIDTH-1:0] res_num;
	logic [RES_DEN_WIDTH-1:0] res_den;
	logic [1:0] order;

	fraction_board board = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	logic hold_req = 0;
	logic hold_done = 0;

	always #5 clk = ~clk;

	rational_arith_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .a_num(a_num), .a_den(a_den),
		.b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_num(res_num), .res_den(res_den), .order(order)
	);

	// Receiver stall: one long hold-off when asked, else random per phase.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			hold_left <= 2999;
			hold_done <= 1'b1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check(res_num, res_den, order);
	end

	// Offer one word at the falling edge and hold it until accepted.
	task automatic send_word(logic [1:0] op, logic signed [NUM_WIDTH-1:0] an,
			logic [DEN_WIDTH-1:0] ad, logic signed [NUM_WIDTH-1:0] bn,
			logic [DEN_WIDTH-1:0] bd);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		do @(posedge clk); while (in_stall);
		board.note(op, an, ad, bn, bd);
		@(negedge clk);
	endtask

	// Numerator: mostly small, sometimes full width or an extreme.
	function automatic logic signed [NUM_WIDTH-1:0] pick_num();
		case ($urandom_range(5, 0))
			0, 1: return $signed($urandom_range(40, 0)) - 20;
			2: return $signed($urandom_range(2000, 0)) - 1000;
			3: return $urandom_range(1, 0) ? 32'sh7fffffff : 32'sh80000000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DEN_WIDTH-1:0] pick_den();
		case ($urandom_range(5, 0))
			0, 1: return DEN_WIDTH'($urandom_range(30, 1));
			2: return DEN_WIDTH'($urandom_range(5000, 1));
			3: return $urandom_range(1, 0) ? 31'h7fffffff : 31'd1;
			default: return DEN_WIDTH'($urandom_range(32'h7fffffff, 1));
		endcase
	endfunction

	task automatic random_words(int count);
		logic [1:0] op;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(19, 0) == 0) ? 2'd3 : 2'($urandom_range(2, 0));
			send_word(op, pick_num(), pick_den(), pick_num(), pick_den());
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes, each operation, zero num/den, unused selector
		send_word(OP_ADD, 1, 2, 1, 3);
		send_word(OP_MUL, 2, 3, 3, 4);
		send_word(OP_CMP, 1, 2, 2, 4);
		send_word(OP_CMP, -1, 2, 1, 3);
		send_word(OP_CMP, 5, 3, 1, 3);
		send_word(2'd3, 7, 5, 3, 2);
		send_word(OP_ADD, 0, 5, 0, 7);
		send_word(OP_MUL, 0, 9, 123, 4);
		send_word(OP_ADD, 3, 0, 4, 5);
		send_word(OP_MUL, 3, 7, 4, 0);
		send_word(OP_CMP, 3, 0, -4, 5);
		send_word(OP_ADD, 1, 2, -1, 2);
		send_word(OP_ADD, 32'sh80000000, 31'h7fffffff, 32'sh80000000, 31'h7fffffff);
		send_word(OP_ADD, 32'sh80000000, 1, 32'sh80000000, 1);
		send_word(OP_ADD, 32'sh7fffffff, 1, 32'sh7fffffff, 1);
		send_word(OP_MUL, 32'sh80000000, 1, 32'sh80000000, 1);
		send_word(OP_MUL, 32'sh7fffffff, 31'h7fffffff, 32'sh80000000, 31'h7ffffffe);
		send_word(OP_MUL, -1, 31'h7fffffff, 1, 31'h7fffffff);
		send_word(OP_CMP, 32'sh80000000, 1, 32'sh7fffffff, 31'h7fffffff);
		send_word(OP_CMP, 32'sh7fffffff, 31'h7fffffff, 32'sh7fffffff, 31'h7fffffff);
		send_word(OP_ADD, 32'sh55555555, 31'h2aaaaaaa, 32'shaaaaaaaa, 31'h55555555);

		// Random phases with different idling
		random_words(450);
		send_idle_pct = 55;
		random_words(350);
		send_idle_pct = 0;
		recv_stall_pct = 55;
		random_words(350);
		send_idle_pct = 38;
		recv_stall_pct = 38;
		random_words(350);

		// Receiver holds off while words keep coming, filling the block
		send_idle_pct = 0;
		recv_stall_pct = 0;
		in_valid <= 1'b0;
		@(negedge clk);
		hold_req = 1'b1;
		random_words(330);
		drain();

		$display("Checked %0d results from %0d words of add, multiply, compare",
			board.words_out, board.words_in);
		$display("and unused selector, under four idling mixes and a long hold-off.");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#400ms;
		$display("Timeout with %0d results outstanding", board.pending.size());
		$display("*** FAILED ***");
		$finish;
	end
endmodule

// File: sim.f
rtl/rau_pkg.sv
rtl/rau_datapath.sv
rtl/rau_ctrl.sv
rtl/rational_arith_unit.sv
verif/rational_arith_unit_tb.sv
